@@ sv/sla_pkg.sv @@
// Package for the serial line assembler: shared constants, codes and control types.
`default_nettype none

package sla_pkg;

   // Default sizes of one line slot (including the spare length position) and of the queue.
   localparam int LINE_SIZE_DEFAULT   = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Received byte classes.
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] PRINTABLE_LO  = 8'h20;
   localparam logic [7:0] PRINTABLE_HI  = 8'h7E;

   // Operation codes of an input item.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW,
      ST_EMPTY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;       // accept a received byte
      logic poll;       // start a poll: take overflow, latch the oldest line
      logic mem_read;   // read the current character of the line
      logic advance;    // current character taken, step to the next one
      logic pop;        // final character taken, release the slot
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic queue_empty;
      logic last_char;
   } status_type;

endpackage

`default_nettype wire

@@ sv/sla_if.sv @@
// Valid/ready channel interfaces for the request and response items.
`default_nettype none

interface sla_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] byte_in;

   modport source (output valid, output operation, output byte_in, input ready);
   modport sink   (input valid, input operation, input byte_in, output ready);
endinterface

interface sla_rsp_if;
   logic       valid;
   logic       ready;
   logic       line_valid;
   logic [7:0] char_out;
   logic       last;
   logic       overflow;

   modport source (output valid, output line_valid, output char_out, output last,
                   output overflow, input ready);
   modport sink   (input valid, input line_valid, input char_out, input last,
                   input overflow, output ready);
endinterface

`default_nettype wire

@@ sv/sla_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module sla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/sla_ctrl.sv @@
// Controller state machine: accepts items and sequences the character stream of a poll.
`default_nettype none

module sla_ctrl
   import sla_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_operation,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      cmd_type    cmd,
   input  wire status_type status
);

   state_type state_ff;
   state_type state_in;
   logic      req_take;
   logic      rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_operation == OP_POLL)) begin
               state_in = status.queue_empty ? ST_EMPTY : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_take) begin
               state_in = status.last_char ? ST_IDLE : ST_READ;
            end
         end
         ST_EMPTY: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands; ready and valid are constant within each state, so
   // the handshakes reduce to the other side's signal here.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.push  = req_valid && (req_operation == OP_PUSH);
            cmd.poll  = req_valid && (req_operation == OP_POLL);
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
         end
         ST_SHOW: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready && !status.last_char;
            cmd.pop     = rsp_ready && status.last_char;
         end
         ST_EMPTY: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/sla_datapath.sv @@
// Datapath: line assembly, slot ring bookkeeping, character memory and response fields.
`default_nettype none

module sla_datapath
   import sla_pkg::*;
#(
   parameter int LINE_SIZE   = LINE_SIZE_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output      status_type status,
   input  wire logic [7:0] byte_in,
   output      logic       line_valid,
   output      logic [7:0] char_out,
   output      logic       last,
   output      logic       overflow
);

   // One physical slot more than the queue holds: the spare one assembles the open line.
   localparam int SLOTS     = QUEUE_DEPTH + 1;
   localparam int IDX_W     = $clog2(LINE_SIZE);
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = SLOTS * (2 ** IDX_W);

   localparam logic [IDX_W-1:0]   LINE_MAX  = IDX_W'(LINE_SIZE - 1);
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(QUEUE_DEPTH);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(QUEUE_DEPTH);

   logic [IDX_W-1:0]   line_len_ff,  line_len_in;
   logic [SLOT_W-1:0]  wr_slot_ff,   wr_slot_in;
   logic [SLOT_W-1:0]  rd_slot_ff,   rd_slot_in;
   logic [COUNT_W-1:0] count_ff,     count_in;
   logic               ovf_flag_ff,  ovf_flag_in;
   logic [IDX_W-1:0]   rd_idx_ff,    rd_idx_in;
   logic               line_mode_ff;
   logic               ovf_out_ff;
   logic [IDX_W-1:0]   poll_last_ff;
   logic [IDX_W-1:0]   slot_len_ff [SLOTS];

   logic               is_end;
   logic               is_print;
   logic               commit;
   logic               mem_wr;
   logic [7:0]         mem_q;

   assign is_end   = (byte_in == CHAR_CR) || (byte_in == CHAR_LF);
   assign is_print = (byte_in >= PRINTABLE_LO) && (byte_in <= PRINTABLE_HI);
   assign commit   = cmd.push && is_end && (line_len_ff != '0) && (count_ff < COUNT_MAX);
   assign mem_wr   = cmd.push && !is_end && is_print && (line_len_ff < LINE_MAX);

   // Byte classification, line length, ring pointers, queue count, read index and overflow flag.
   always_comb begin
      line_len_in = line_len_ff;
      wr_slot_in  = wr_slot_ff;
      rd_slot_in  = rd_slot_ff;
      count_in    = count_ff;
      ovf_flag_in = ovf_flag_ff;
      rd_idx_in   = rd_idx_ff;
      if (cmd.push) begin
         if (is_end) begin
            if (line_len_ff != '0) begin
               if (count_ff < COUNT_MAX) begin
                  wr_slot_in = (wr_slot_ff == SLOT_LAST) ? '0 : wr_slot_ff + 1'b1;
                  count_in   = count_ff + 1'b1;
               end else begin
                  ovf_flag_in = 1'b1;
               end
               line_len_in = '0;
            end
         end else if (is_print) begin
            if (line_len_ff < LINE_MAX) begin
               line_len_in = line_len_ff + 1'b1;
            end else begin
               line_len_in = '0;
               ovf_flag_in = 1'b1;
            end
         end else begin
            line_len_in = '0;
         end
      end
      if (cmd.poll) begin
         ovf_flag_in = 1'b0;
         rd_idx_in   = '0;
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
      if (cmd.pop) begin
         rd_slot_in = (rd_slot_ff == SLOT_LAST) ? '0 : rd_slot_ff + 1'b1;
         count_in   = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= '0;
         wr_slot_ff  <= '0;
         rd_slot_ff  <= '0;
         count_ff    <= '0;
         ovf_flag_ff <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         line_len_ff <= line_len_in;
         wr_slot_ff  <= wr_slot_in;
         rd_slot_ff  <= rd_slot_in;
         count_ff    <= count_in;
         ovf_flag_ff <= ovf_flag_in;
         rd_idx_ff   <= rd_idx_in;
      end
   end

   // Slot lengths and the fields captured at the start of a poll.
   always_ff @(posedge clock) begin
      if (commit) begin
         slot_len_ff[wr_slot_ff] <= line_len_ff;
      end
      if (cmd.poll) begin
         line_mode_ff <= (count_ff != '0);
         ovf_out_ff   <= ovf_flag_ff;
         poll_last_ff <= slot_len_ff[rd_slot_ff] - 1'b1;
      end
   end

   // Character store: one region per physical slot, addressed by slot and position.
   sla_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr ({wr_slot_ff, line_len_ff}),
      .wr_data (byte_in),
      .rd_en   (cmd.mem_read),
      .rd_addr ({rd_slot_ff, rd_idx_ff}),
      .rd_data (mem_q)
   );

   assign status.queue_empty = (count_ff == '0);
   assign status.last_char   = (rd_idx_ff == poll_last_ff);

   // Response fields; an empty poll gives a single item with no character.
   assign line_valid = line_mode_ff;
   assign char_out   = line_mode_ff ? mem_q : 8'h00;
   assign last       = line_mode_ff ? (rd_idx_ff == poll_last_ff) : 1'b1;
   assign overflow   = ovf_out_ff;

endmodule

`default_nettype wire

@@ sv/serial_line_assembler_queue.sv @@
// Top level of the serial line assembler with its queue of complete lines.
// A push item is accepted in the idle state: printable bytes are written straight into the
// slot that is being assembled, and CR or LF closes the line by recording its length, so no
// copy is made. After a poll item is accepted, the oldest line is streamed character by
// character: each one is read from the registered character memory and then presented
// until it is taken, or one item marked not valid is given when the queue is empty. No new
// item is accepted until the last item of a poll has been taken. The character memory holds
// QUEUE_DEPTH+1 slot regions; no clearing pass is needed after reset.
`default_nettype none

module serial_line_assembler_queue
   import sla_pkg::*;
#(
   parameter int LINE_SIZE   = LINE_SIZE_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   sla_req_if.sink   req_ch,
   sla_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of items.
   sla_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .cmd           (cmd),
      .status        (status)
   );

   // Line storage and response fields.
   sla_datapath #(
      .LINE_SIZE   (LINE_SIZE),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .byte_in    (req_ch.byte_in),
      .line_valid (rsp_ch.line_valid),
      .char_out   (rsp_ch.char_out),
      .last       (rsp_ch.last),
      .overflow   (rsp_ch.overflow)
   );

endmodule

`default_nettype wire
